// ===== hdl/power_on_sequencer_unit_macros.svh =====
// Assertion macros shared by the power-on sequencer RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef POWER_ON_SEQUENCER_UNIT_MACROS_SVH
`define POWER_ON_SEQUENCER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define POS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define POS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   `POS_ASSERT(label, clk, rst, (ante) |-> (cons), msg)
`define POS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   `POS_ASSERT(label, clk, rst, (ante) |=> (cons), msg)
`else
`define POS_ASSERT(label, clk, rst, prop, msg)
`define POS_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define POS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== hdl/pos_pkg.sv =====
// Types, register map and reset constants of the power-on sequencer.
// No dependencies; used by the request interface and every module of the block.
`default_nettype none

package pos_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int TIME_W     = 64;
   localparam int CFG_W      = 32;

   typedef logic [1:0] reg_index_type;

   localparam reg_index_type REG_PSU_SETTLE   = 2'd0;
   localparam reg_index_type REG_SWITCH_PULSE = 2'd1;
   localparam reg_index_type REG_DEBOUNCE     = 2'd2;
   localparam reg_index_type REG_OFF_CONFIRM  = 2'd3;

   localparam logic [CFG_W-1:0] PSU_SETTLE_RESET   = 32'd1000000;
   localparam logic [CFG_W-1:0] SWITCH_PULSE_RESET = 32'd300000;
   localparam logic [CFG_W-1:0] DEBOUNCE_RESET     = 32'd30000;
   localparam logic [CFG_W-1:0] OFF_CONFIRM_RESET  = 32'd3000000;

   typedef enum logic [1:0] {
      PHASE_IDLE   = 2'd0,
      PHASE_SETTLE = 2'd1,
      PHASE_PULSE  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [CFG_W-1:0] psu_settle_time;
      logic [CFG_W-1:0] switch_pulse_time;
      logic [CFG_W-1:0] debounce_time;
      logic [CFG_W-1:0] off_confirm_time;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0] now_us;
      logic              rail_present;
      logic              link_connected;
      logic              button_level;
   } item_type;

   typedef struct packed {
      logic      psu_enable;
      logic      switch_pressed;
      logic      disconnect_request;
      phase_type phase;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/pos_ifs.sv =====
// Valid/ready channel interfaces for poll items and result items.
// Depends on pos_pkg for the field widths.
`default_nettype none

interface pos_req_if;
   logic                        valid;
   logic                        ready;
   logic [pos_pkg::TIME_W-1:0]  now_us;
   logic                        rail_present;
   logic                        link_connected;
   logic                        button_level;

   modport source (output valid, now_us, rail_present, link_connected, button_level,
                   input ready);
   modport sink (input valid, now_us, rail_present, link_connected, button_level,
                 output ready);
endinterface

interface pos_rsp_if;
   logic       valid;
   logic       ready;
   logic       psu_enable;
   logic       switch_pressed;
   logic       disconnect_request;
   logic [1:0] phase;

   modport source (output valid, psu_enable, switch_pressed, disconnect_request, phase,
                   input ready);
   modport sink (input valid, psu_enable, switch_pressed, disconnect_request, phase,
                 output ready);
endinterface

`default_nettype wire

// ===== hdl/pos_csr.sv =====
// APB-style configuration registers of the power-on sequencer.
// Depends on pos_pkg for the register map and reset values.
`default_nettype none

module pos_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pos_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pos_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pos_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output pos_pkg::cfg_type                cfg
);
   import pos_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_index;
   logic          wr_en;

   assign reg_index  = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_PSU_SETTLE:   cfg_in.psu_settle_time   = csr_pwdata;
            REG_SWITCH_PULSE: cfg_in.switch_pulse_time = csr_pwdata;
            REG_DEBOUNCE:     cfg_in.debounce_time     = csr_pwdata;
            REG_OFF_CONFIRM:  cfg_in.off_confirm_time  = csr_pwdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_PSU_SETTLE:   csr_prdata = cfg_ff.psu_settle_time;
         REG_SWITCH_PULSE: csr_prdata = cfg_ff.switch_pulse_time;
         REG_DEBOUNCE:     csr_prdata = cfg_ff.debounce_time;
         REG_OFF_CONFIRM:  csr_prdata = cfg_ff.off_confirm_time;
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.psu_settle_time   <= PSU_SETTLE_RESET;
         cfg_ff.switch_pulse_time <= SWITCH_PULSE_RESET;
         cfg_ff.debounce_time     <= DEBOUNCE_RESET;
         cfg_ff.off_confirm_time  <= OFF_CONFIRM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/pos_core.sv =====
// Sequencer state and the single-pass update applied to each poll item.
// Depends on pos_pkg and the assertion macros header.
`default_nettype none
`include "power_on_sequencer_unit_macros.svh"

module pos_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  pos_pkg::item_type   item,
   input  pos_pkg::cfg_type    cfg,
   output pos_pkg::result_type result
);
   import pos_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [TIME_W-1:0] phase_start_ff, phase_start_in;
   logic              psu_drive_ff, psu_drive_in;
   logic              switch_drive_ff, switch_drive_in;
   logic              prev_link_ff, prev_link_in;
   logic              prev_rail_ff, prev_rail_in;
   logic              rail_seen_on_ff, rail_seen_on_in;
   logic [TIME_W-1:0] rail_absent_start_ff, rail_absent_start_in;
   logic              button_stable_ff, button_stable_in;
   logic              button_last_raw_ff, button_last_raw_in;
   logic [TIME_W-1:0] button_change_time_ff, button_change_time_in;
   logic              started_ff, started_in;

   logic              pressed;
   logic              rail;
   logic              link;
   logic [TIME_W-1:0] now;
   logic              disc;
   logic              press_edge;
   logic              link_edge;

   function automatic logic reached(input logic [TIME_W-1:0] t_now,
                                    input logic [TIME_W-1:0] t_start,
                                    input logic [CFG_W-1:0]  limit);
      logic [TIME_W-1:0] delta;
      delta = t_now - t_start;
      return delta >= {{(TIME_W-CFG_W){1'b0}}, limit};
   endfunction

   assign now       = item.now_us;
   assign rail      = item.rail_present;
   assign link      = item.link_connected;
   assign pressed   = ~item.button_level;
   assign link_edge = link && !prev_link_ff;

   always_comb begin
      phase_in              = phase_ff;
      phase_start_in        = phase_start_ff;
      psu_drive_in          = psu_drive_ff;
      switch_drive_in       = switch_drive_ff;
      prev_link_in          = prev_link_ff;
      prev_rail_in          = prev_rail_ff;
      rail_seen_on_in       = rail_seen_on_ff;
      rail_absent_start_in  = rail_absent_start_ff;
      button_stable_in      = button_stable_ff;
      button_last_raw_in    = button_last_raw_ff;
      button_change_time_in = button_change_time_ff;
      started_in            = 1'b1;
      disc                  = 1'b0;
      press_edge            = 1'b0;

      if (!started_ff) begin
         phase_in              = PHASE_IDLE;
         psu_drive_in          = 1'b0;
         switch_drive_in       = 1'b0;
         prev_link_in          = link;
         prev_rail_in          = rail;
         rail_seen_on_in       = 1'b0;
         rail_absent_start_in  = now;
         button_stable_in      = 1'b0;
         button_last_raw_in    = pressed;
         button_change_time_in = now;
      end else begin
         case (phase_ff)
            PHASE_SETTLE: begin
               if (reached(now, phase_start_ff, cfg.psu_settle_time)) begin
                  switch_drive_in = 1'b1;
                  phase_start_in  = now;
                  phase_in        = PHASE_PULSE;
               end
            end
            PHASE_PULSE: begin
               if (reached(now, phase_start_ff, cfg.switch_pulse_time)) begin
                  switch_drive_in = 1'b0;
                  phase_in        = PHASE_IDLE;
               end
            end
            default: begin
               if (link) begin
                  if (rail) begin
                     rail_seen_on_in = 1'b1;
                  end else if (prev_rail_ff) begin
                     rail_absent_start_in = now;
                  end
                  if (rail_seen_on_in && !rail &&
                      reached(now, rail_absent_start_in, cfg.off_confirm_time)) begin
                     disc            = 1'b1;
                     rail_seen_on_in = 1'b0;
                  end
               end else begin
                  rail_seen_on_in = 1'b0;
               end
               prev_rail_in = rail;
               prev_link_in = link;

               button_last_raw_in = pressed;
               if (pressed != button_last_raw_ff) begin
                  button_change_time_in = now;
               end
               if (reached(now, button_change_time_in, cfg.debounce_time) &&
                   pressed != button_stable_ff) begin
                  button_stable_in = pressed;
                  press_edge       = pressed;
               end

               if ((link_edge || press_edge) && !rail) begin
                  psu_drive_in   = 1'b1;
                  phase_start_in = now;
                  phase_in       = PHASE_SETTLE;
               end
            end
         endcase
      end
   end

   assign result.psu_enable         = psu_drive_in;
   assign result.switch_pressed     = switch_drive_in;
   assign result.disconnect_request = disc;
   assign result.phase              = phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff       <= 1'b0;
         phase_ff         <= PHASE_IDLE;
         psu_drive_ff     <= 1'b0;
         switch_drive_ff  <= 1'b0;
         rail_seen_on_ff  <= 1'b0;
         button_stable_ff <= 1'b0;
      end else if (step_en) begin
         started_ff       <= started_in;
         phase_ff         <= phase_in;
         psu_drive_ff     <= psu_drive_in;
         switch_drive_ff  <= switch_drive_in;
         rail_seen_on_ff  <= rail_seen_on_in;
         button_stable_ff <= button_stable_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         phase_start_ff        <= phase_start_in;
         prev_link_ff          <= prev_link_in;
         prev_rail_ff          <= prev_rail_in;
         rail_absent_start_ff  <= rail_absent_start_in;
         button_last_raw_ff    <= button_last_raw_in;
         button_change_time_ff <= button_change_time_in;
      end
   end

   `POS_ASSERT(a_switch_matches_phase, clock, reset, switch_drive_ff == (phase_ff == PHASE_PULSE), "Switch drive is out of step with the phase.")
   `POS_ASSERT_IMP(a_psu_during_sequence, clock, reset, phase_ff != PHASE_IDLE, psu_drive_ff, "PSU is off while a sequence runs.")
   `POS_ASSERT_NEXT(a_first_item_latches, clock, reset, step_en && !started_ff, started_ff && (phase_ff == PHASE_IDLE) && !psu_drive_ff, "First item did not leave the sequencer idle.")

endmodule

`default_nettype wire

// ===== hdl/power_on_sequencer_unit.sv =====
// Power-on sequencer top level: input register, update logic, result register.
// A poll item is captured in the input register when accepted; the update logic
// runs on it when the result register is free or being taken, and the result
// register then holds its result item until taken. One item per cycle while the
// result port does not stall; the next item sees the state that the last one left.
// Reset clears the sequencer state and restores the register defaults; the
// first item after reset only latches levels and timestamps.
`default_nettype none

module power_on_sequencer_unit (
   input  logic                            clock,
   input  logic                            reset,
   pos_req_if.sink                         req_port,
   pos_rsp_if.source                       rsp_port,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pos_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pos_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pos_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import pos_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   logic       in_valid_ff, in_valid_in;
   result_type result;
   result_type result_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;
   logic       req_accept;

   pos_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pos_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_port.ready);
   assign req_port.ready = !in_valid_ff || advance;
   assign req_accept     = req_port.valid && req_port.ready;

   assign in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_port.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.now_us         <= req_port.now_us;
         item_ff.rail_present   <= req_port.rail_present;
         item_ff.link_connected <= req_port.link_connected;
         item_ff.button_level   <= req_port.button_level;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_port.valid              = rsp_valid_ff;
   assign rsp_port.psu_enable         = result_ff.psu_enable;
   assign rsp_port.switch_pressed     = result_ff.switch_pressed;
   assign rsp_port.disconnect_request = result_ff.disconnect_request;
   assign rsp_port.phase              = result_ff.phase;

endmodule

`default_nettype wire
